// ----- sv/lfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared types and constants of the lowest free slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsa_pkg;

  // bitmap word held in one memory row
  localparam int WORD_W    = 64;
  localparam int OFF_W     = 6;
  localparam int SLOTS_DEF = 1024;

  // stream payload widths
  localparam int INDEX_W = 10;
  localparam int GRANT_W = 10;
  localparam int TDATA_W = 16;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } lfsa_cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RELEASE
  } lfsa_state_e;

  // outcome of the free bit search over one word
  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] bit_idx;
  } lfsa_hit_t;

endpackage

`default_nettype wire

// ----- sv/lfsa_ram.sv -----
// ----------------------------------------------------------------------------
// lfsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/lfsa_find.sv -----
// ----------------------------------------------------------------------------
// lfsa_find
// Lowest set bit search over one bitmap word of free flags.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsa_find (
  input  wire logic [lfsa_pkg::WORD_W-1:0] free_i,
  output lfsa_pkg::lfsa_hit_t              hit_o
);

  import lfsa_pkg::*;

  logic [WORD_W-1:0] iso;
  logic [WORD_W-1:0] sel [OFF_W];

  // isolate the lowest free bit, then encode its position bit by bit
  assign iso = free_i & (~free_i + WORD_W'(1));

  always_comb begin
    for (int k = 0; k < OFF_W; k++) begin
      for (int j = 0; j < WORD_W; j++) begin
        sel[k][j] = iso[j] & ((j >> k) % 2 == 1);
      end
    end
  end

  always_comb begin
    hit_o.found = |free_i;
    for (int k = 0; k < OFF_W; k++) begin
      hit_o.bit_idx[k] = |sel[k];
    end
  end

endmodule

`default_nettype wire

// ----- sv/lowest_free_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_unit
// First-fit slot allocator over an occupancy bitmap with a search hint.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis group: tuser selects allocate (0) or release
// (1), tdata carries the slot to release. Each request yields one response on
// the m_axis group: tdata is the granted slot (0 unless an allocate succeeded),
// tuser flags an allocate that found no free slot.
// The bitmap lives in a memory of 64-bit words, SLOTS/64 rows rounded up
// (16 for 1024 slots). An allocate reads one word per cycle starting at the
// hint word; a release is a single read-modify-write. A release out of range
// or an allocate with the hint past the last slot answers without a memory
// read. One request is processed at a time.
// After reset a clearing pass writes every row to zero, one row per cycle;
// requests are held off until it ends.
// The response register plus one pending slot decouple the sides: a stalled
// receiver holds the response, and new requests wait while a request is in
// process or the pending slot is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_slot_allocator_unit #(
  parameter int SLOTS = lfsa_pkg::SLOTS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [lfsa_pkg::TDATA_W-1:0] s_axis_tdata_i,  // [9:0] slot_index
  input  wire logic                         s_axis_tuser_i,  // [0] cmd
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic      [lfsa_pkg::TDATA_W-1:0] m_axis_tdata_o,  // [9:0] granted_slot
  output logic                              m_axis_tuser_o   // [0] failed
);

  import lfsa_pkg::*;

  localparam int WORDS = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int HW    = $clog2(SLOTS + 1);
  localparam int TAIL  = SLOTS - (WORDS - 1) * WORD_W;
  localparam logic [AW-1:0]     LAST_WORD = AW'(WORDS - 1);
  localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - TAIL);

  lfsa_state_e state_q, state_d;
  logic [HW-1:0]      hint_q, hint_d;
  logic [AW-1:0]      word_q, word_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [INDEX_W-1:0] rel_slot_q, rel_slot_d;

  logic               out_valid_q;
  logic [GRANT_W-1:0] out_slot_q;
  logic               out_fail_q;
  logic               pend_valid_q;
  logic [GRANT_W-1:0] pend_slot_q;
  logic               pend_fail_q;

  logic               res_valid;
  logic [GRANT_W-1:0] res_slot;
  logic               res_fail;
  logic               out_free;
  logic               in_fire;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [WORD_W-1:0] free_word;
  lfsa_hit_t         hit;
  logic [WORD_W-1:0] hit_bit;
  logic [WORD_W-1:0] rel_bit;

  lfsa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WORDS),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // free flags of the word in flight, limited to the search window
  always_comb begin
    free_word = ~ram_rdata & ({WORD_W{1'b1}} << off_q);
    if (word_q == LAST_WORD) begin
      free_word = free_word & LAST_MASK;
    end
  end

  lfsa_find u_find (
    .free_i(free_word),
    .hit_o (hit)
  );

  assign hit_bit  = WORD_W'(1) << hit.bit_idx;
  assign rel_bit  = WORD_W'(1) << OFF_W'(rel_slot_q);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && !pend_valid_q;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d    = state_q;
    hint_d     = hint_q;
    word_d     = word_q;
    off_d      = off_q;
    clr_d      = clr_q;
    rel_slot_d = rel_slot_q;
    ram_we     = 1'b0;
    ram_waddr  = word_q;
    ram_wdata  = '0;
    ram_raddr  = word_q;
    res_valid  = 1'b0;
    res_slot   = '0;
    res_fail   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          if (lfsa_cmd_e'(s_axis_tuser_i) == CMD_ALLOC) begin
            if (32'(hint_q) < SLOTS) begin
              ram_raddr = AW'(hint_q >> OFF_W);
              word_d    = AW'(hint_q >> OFF_W);
              off_d     = OFF_W'(hint_q);
              state_d   = ST_SCAN;
            end else begin
              res_valid = 1'b1;
              res_fail  = 1'b1;
            end
          end else begin
            if (32'(s_axis_tdata_i[INDEX_W-1:0]) < SLOTS) begin
              ram_raddr  = AW'(s_axis_tdata_i[INDEX_W-1:0] >> OFF_W);
              word_d     = AW'(s_axis_tdata_i[INDEX_W-1:0] >> OFF_W);
              rel_slot_d = s_axis_tdata_i[INDEX_W-1:0];
              state_d    = ST_RELEASE;
            end else begin
              res_valid = 1'b1;
            end
          end
        end
      end

      ST_SCAN: begin
        if (hit.found) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | hit_bit;
          hint_d    = HW'((AW + OFF_W + 1)'({word_q, hit.bit_idx}) + (AW + OFF_W + 1)'(1));
          res_valid = 1'b1;
          res_slot  = GRANT_W'({word_q, hit.bit_idx});
          state_d   = ST_IDLE;
        end else if (word_q == LAST_WORD) begin
          res_valid = 1'b1;
          res_fail  = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          // advance to the next word, whole word in the window
          ram_raddr = word_q + AW'(1);
          word_d    = word_q + AW'(1);
          off_d     = '0;
        end
      end

      ST_RELEASE: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~rel_bit;
        if (32'(rel_slot_q) < 32'(hint_q)) begin
          hint_d = HW'(rel_slot_q);
        end
        res_valid = 1'b1;
        state_d   = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      hint_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    off_q      <= off_d;
    rel_slot_q <= rel_slot_d;
  end

  // response register with one pending slot behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q  <= pend_valid_q || res_valid;
        pend_valid_q <= 1'b0;
      end else if (res_valid) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_slot_q <= pend_slot_q;
        out_fail_q <= pend_fail_q;
      end else if (res_valid) begin
        out_slot_q <= res_slot;
        out_fail_q <= res_fail;
      end
    end else if (res_valid) begin
      pend_slot_q <= res_slot;
      pend_fail_q <= res_fail;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TDATA_W'(out_slot_q);
  assign m_axis_tuser_o  = out_fail_q;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the lowest free slot allocator unit.
// ----------------------------------------------------------------------------
// Drives allocate and release requests on the request stream. It predicts each
// response from its own copy of the occupancy bitmap and search hint, and
// checks every response against the oldest prediction. The run covers a short
// directed sequence, random churn at low occupancy, filling the pool until
// allocations fail, and churn near full. The sender sends random bursts with
// pauses between them, and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------

module tb_top;
  import lfsa_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [GRANT_W-1:0] granted_slot;
    logic               failed;
  } grant_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [TDATA_W-1:0] s_axis_tdata_i;   // [9:0] slot_index
  logic               s_axis_tuser_i;   // [0] cmd
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [TDATA_W-1:0] m_axis_tdata_o;   // [9:0] granted_slot
  logic               m_axis_tuser_o;   // [0] failed

  // model state of the allocator
  bit          slot_used [SLOTS];
  int unsigned search_hint = 0;
  int unsigned used_count  = 0;

  grant_t      pending_grants [$];
  int unsigned cycle_count = 0;
  bit          failures    = 1'b0;
  int unsigned burst_left  = 0;
  int unsigned ready_left  = 0;
  int unsigned stall_left  = 0;

  lowest_free_slot_allocator_unit #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Update the bitmap and hint for one request and return its response.
  function automatic grant_t predict_grant(lfsa_cmd_e cmd, logic [INDEX_W-1:0] slot);
    grant_t      res;
    int unsigned s;
    res = '0;
    if (cmd == CMD_ALLOC) begin
      res.failed = 1'b1;
      for (int unsigned i = search_hint; i < SLOTS; i++) begin
        if (!slot_used[i]) begin
          slot_used[i]     = 1'b1;
          used_count++;
          search_hint      = i + 1;
          res.granted_slot = GRANT_W'(i);
          res.failed       = 1'b0;
          break;
        end
      end
    end else begin
      s = 32'(slot);
      if (s < SLOTS) begin
        if (slot_used[s]) used_count--;
        slot_used[s] = 1'b0;
        if (s < search_hint) search_hint = s;
      end
    end
    return res;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_used_slot();
    int unsigned start;
    start = $urandom_range(SLOTS - 1, 0);
    for (int unsigned k = 0; k < SLOTS; k++) begin
      if (slot_used[(start + k) % SLOTS]) return INDEX_W'((start + k) % SLOTS);
    end
    return INDEX_W'(start);
  endfunction

  task automatic send_request(input lfsa_cmd_e cmd, input logic [INDEX_W-1:0] slot);
    // drop valid for a random gap between bursts
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 40)
                                               : $urandom_range(12, 1);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= TDATA_W'(slot);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_grants.push_back(predict_grant(cmd, slot));
    burst_left--;
  endtask

  task automatic test_directed();
    repeat (3) send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, 10'h3FF);      // index ignored on allocate
    send_request(CMD_RELEASE, 10'd1);
    send_request(CMD_ALLOC, '0);           // reuse the released slot
    send_request(CMD_ALLOC, '0);
    send_request(CMD_RELEASE, 10'd0);
    send_request(CMD_RELEASE, 10'd2);
    send_request(CMD_RELEASE, 10'd2);      // release of a free slot
    send_request(CMD_ALLOC, 10'h155);
    send_request(CMD_ALLOC, 10'h2AA);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_RELEASE, 10'h3FF);    // free slot at the top
    send_request(CMD_RELEASE, 10'h2AA);
    send_request(CMD_RELEASE, 10'h155);
    send_request(CMD_RELEASE, 10'd200);
  endtask

  task automatic test_random_churn(input int unsigned n);
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99, 0);
      if (pick < 50) begin
        send_request(CMD_ALLOC, INDEX_W'($urandom));
      end else if (pick < 85 && used_count > 0) begin
        send_request(CMD_RELEASE, pick_used_slot());
      end else begin
        send_request(CMD_RELEASE, INDEX_W'($urandom_range(SLOTS - 1, 0)));
      end
    end
  endtask

  task automatic test_pool_full();
    while (used_count < SLOTS) send_request(CMD_ALLOC, INDEX_W'($urandom));
    // pool is full: these must fail
    repeat (4) send_request(CMD_ALLOC, INDEX_W'($urandom));
    send_request(CMD_RELEASE, 10'h3FF);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, '0);
  endtask

  task automatic test_full_churn(input int unsigned n);
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99, 0);
      if (pick < 50) begin
        send_request(CMD_ALLOC, INDEX_W'($urandom));
      end else if (pick < 95 && used_count > 0) begin
        send_request(CMD_RELEASE, pick_used_slot());
      end else begin
        send_request(CMD_RELEASE, INDEX_W'($urandom_range(SLOTS - 1, 0)));
      end
    end
  endtask

  always @(posedge clk_i) begin : response_check
    grant_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_grants.size() == 0) begin
          $error("response with no request waiting: granted_slot %0d, failed %0b",
                 m_axis_tdata_o[GRANT_W-1:0], m_axis_tuser_o);
          failures = 1'b1;
        end else begin
          want = pending_grants.pop_front();
          if (m_axis_tdata_o[GRANT_W-1:0] !== want.granted_slot) begin
            $error("granted_slot mismatch: expected %0d, actual %0d",
                   want.granted_slot, m_axis_tdata_o[GRANT_W-1:0]);
            failures = 1'b1;
          end
          if (m_axis_tuser_o !== want.failed) begin
            $error("failed mismatch: expected %0b, actual %0b", want.failed, m_axis_tuser_o);
            failures = 1'b1;
          end
        end
      end
      // receiver stall pattern: ready runs, some long, split by short stalls
      if (ready_left > 0) begin
        ready_left--;
        m_axis_tready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        ready_left = ($urandom_range(5, 0) == 0) ? 60 : $urandom_range(20, 1);
        stall_left = $urandom_range(6, 1);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= CMD_ALLOC;
    m_axis_tready_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_churn(60);
    test_pool_full();
    test_full_churn(40);

    s_axis_tvalid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_grants.size() != 0) begin
      $error("%0d requests left without response", pending_grants.size());
      failures = 1'b1;
    end
    if (!failures) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
